>>> hdl/bzf_pkg.sv
// ----------------------------------------------------------------------------
// bzf_pkg: shared types and constants of the cubic Bezier flattener
// Coordinate widths, subdivision depth, item structs and flatness status.
// ----------------------------------------------------------------------------
package bzf_pkg;

  // Subdivision depth limit and coordinate width (signed Q15.8 at 24 bits).
  localparam int MAX_LEVEL   = 6;
  localparam int COORD_WIDTH = 24;

  // Level and stack pointer hold 0 .. MAX_LEVEL.
  localparam int LEVEL_WIDTH = $clog2(MAX_LEVEL + 1);
  // Emitted point counter; a run has at most 2^MAX_LEVEL points.
  localparam int CNT_WIDTH   = MAX_LEVEL;

  // Flatness tolerance register, unsigned Q8.8.
  localparam int TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(64);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LEVEL_WIDTH-1:0]        level_t;
  typedef logic [TOL_WIDTH-1:0]          tol_t;

  // Eight coordinates of one segment: x1 y1 x2 y2 x3 y3 x4 y4 at index 0..7.
  typedef coord_t [7:0] seg_t;

  // One pending right half on the subdivision stack.
  typedef struct packed {
    seg_t   coords;
    level_t level;
  } stack_entry_t;

  localparam int ENTRY_WIDTH = $bits(stack_entry_t);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   point_valid;
    logic   last_point;
  } out_item_t;

  // Status from the flatness unit to the sequencer.
  typedef struct packed {
    logic done;
    logic flat;
  } flat_status_t;

endpackage

>>> hdl/cubic_bezier_flattener_top.sv
// ----------------------------------------------------------------------------
// Each visited segment starts the flatness unit, waits for the result of its
// shared multiplier and is then decided; a segment that is not split then
// pops the next pending half from the stack RAM. A curve visits up to 127
// segments, and a flat one may wait for a stalled output.
// One curve is worked on at a time; the last result can wait at the output.
// Reset is synchronous and active high; the stack RAM needs no clearing.
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_top: adaptive cubic Bezier subdivision
// Sequencer, current segment registers, stack RAM of pending right halves
// and the output register.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bzf_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bzf_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bzf_pkg::TOL_WIDTH-1:0] cfg_data
);

  localparam int CW    = bzf_pkg::COORD_WIDTH;
  localparam int LVW   = bzf_pkg::LEVEL_WIDTH;
  localparam int DEPTH = bzf_pkg::MAX_LEVEL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LVW-1:0] MAXL = LVW'(bzf_pkg::MAX_LEVEL);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_START  = 7'b0000010,
    S_WAIT   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_POP    = 7'b0010000,
    S_LOAD   = 7'b0100000,
    S_FINAL  = 7'b1000000
  } state_t;

  state_t                    state;
  bzf_pkg::tol_t             tol;
  bzf_pkg::seg_t             seg;
  bzf_pkg::level_t           level;
  logic [LVW-1:0]            top;
  logic [bzf_pkg::CNT_WIDTH-1:0] cnt;
  bzf_pkg::coord_t           held_x, held_y;
  logic                      held_valid;
  logic                      flat_q;
  bzf_pkg::flat_status_t     fs;
  logic                      out_free;
  logic                      out_load;
  logic                      wr_en, rd_en;
  logic [LVW-1:0]            top_dec;
  bzf_pkg::stack_entry_t     wr_entry, rd_entry;
  logic [bzf_pkg::ENTRY_WIDTH-1:0] rd_bits;
  bzf_pkg::coord_t           x12, y12, x23, y23, x34, y34;
  bzf_pkg::coord_t           x123, y123, x234, y234, xm, ym;

  // Floor of the mean of two coordinates.
  function automatic bzf_pkg::coord_t mid(bzf_pkg::coord_t a, bzf_pkg::coord_t b);
    logic signed [CW:0] sum;
    sum = (CW + 1)'(a) + (CW + 1)'(b);
    return sum[CW:1];
  endfunction

  // Configuration register; writes must arrive only while the block is idle; the block does not enforce this.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= bzf_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // A result enters the output register when a held point is released or
  // when the run ends.
  assign out_load = out_free &&
                    (((state == S_DECIDE) && flat_q && held_valid && (cnt != '1)) ||
                     (state == S_FINAL));

  // Midpoint split of the current segment.
  assign x12  = mid(seg[0], seg[2]);
  assign y12  = mid(seg[1], seg[3]);
  assign x23  = mid(seg[2], seg[4]);
  assign y23  = mid(seg[3], seg[5]);
  assign x34  = mid(seg[4], seg[6]);
  assign y34  = mid(seg[5], seg[7]);
  assign x123 = mid(x12, x23);
  assign y123 = mid(y12, y23);
  assign x234 = mid(x23, x34);
  assign y234 = mid(y23, y34);
  assign xm   = mid(x123, x234);
  assign ym   = mid(y123, y234);

  // Right half pushed onto the stack.
  always_comb begin
    wr_entry.coords[0] = xm;
    wr_entry.coords[1] = ym;
    wr_entry.coords[2] = x234;
    wr_entry.coords[3] = y234;
    wr_entry.coords[4] = x34;
    wr_entry.coords[5] = y34;
    wr_entry.coords[6] = seg[6];
    wr_entry.coords[7] = seg[7];
    wr_entry.level     = level + 1'b1;
  end

  assign wr_en   = (state == S_DECIDE) && !flat_q && (level < MAXL) && (top < MAXL);
  assign rd_en   = (state == S_POP) && (top != '0);
  assign top_dec = top - 1'b1;
  assign rd_entry = rd_bits;

  bzf_stack_ram #(
    .WIDTH (bzf_pkg::ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (top[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (top_dec[AW-1:0]),
    .rd_data (rd_bits)
  );

  bzf_flat_unit u_flat (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_START),
    .seg    (seg),
    .tol    (tol),
    .status (fs)
  );

  // Output valid flag: set on a load, cleared once the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer: test, then split, emit, or drop a non-flat segment at the depth limit, then pop the next pending half.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top        <= '0;
      level      <= '0;
      cnt        <= '0;
      held_valid <= 1'b0;
      held_x     <= '0;
      held_y     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            seg[0]     <= in_data.start_x;
            seg[1]     <= in_data.start_y;
            seg[2]     <= in_data.ctrl1_x;
            seg[3]     <= in_data.ctrl1_y;
            seg[4]     <= in_data.ctrl2_x;
            seg[5]     <= in_data.ctrl2_y;
            seg[6]     <= in_data.end_x;
            seg[7]     <= in_data.end_y;
            level      <= '0;
            top        <= '0;
            cnt        <= '0;
            held_valid <= 1'b0;
            held_x     <= '0;
            held_y     <= '0;
            state      <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (fs.done) begin
            flat_q <= fs.flat;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (flat_q) begin
            // A flat segment releases the held point while the count allows, and holds its end point.
            if (held_valid && (cnt != '1)) begin
              if (out_free) begin
                out_data.point_x     <= held_x;
                out_data.point_y     <= held_y;
                out_data.point_valid <= 1'b1;
                out_data.last_point  <= 1'b0;
                cnt                  <= cnt + 1'b1;
                held_x               <= seg[6];
                held_y               <= seg[7];
                state                <= S_POP;
              end
            end else begin
              held_x     <= seg[6];
              held_y     <= seg[7];
              held_valid <= 1'b1;
              state      <= S_POP;
            end
          end else if (wr_en) begin
            // Keep the left half and push the right half.
            seg[2] <= x12;
            seg[3] <= y12;
            seg[4] <= x123;
            seg[5] <= y123;
            seg[6] <= xm;
            seg[7] <= ym;
            level  <= level + 1'b1;
            top    <= top + 1'b1;
            state  <= S_START;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (top == '0) begin
            state <= S_FINAL;
          end else begin
            top   <= top_dec;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          seg   <= rd_entry.coords;
          level <= rd_entry.level;
          state <= S_START;
        end
        S_FINAL: begin
          if (out_free) begin
            out_data.point_x     <= held_valid ? held_x : '0;
            out_data.point_y     <= held_valid ? held_y : '0;
            out_data.point_valid <= held_valid;
            out_data.last_point  <= 1'b1;
            held_valid           <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stack never holds more than the level limit.
  a_top_bound: assert property (@(posedge clk) disable iff (rst) top <= MAXL)
    else $error("stack pointer beyond level limit");

  // A segment is never deeper than the level limit.
  a_level_bound: assert property (@(posedge clk) disable iff (rst) level <= MAXL)
    else $error("segment level beyond level limit");

  // An empty stack at pop ends the run.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) && (top == '0) |=> (state == S_FINAL))
    else $error("empty stack did not end the run");

  // Flatness results only arrive while the sequencer waits for them.
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    fs.done |-> (state == S_WAIT))
    else $error("flatness result outside wait state");

  // The empty marker is always the last result of a run.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.point_valid |-> out_data.last_point)
    else $error("empty marker without last flag");

endmodule

>>> hdl/bzf_stack_ram.sv
// ----------------------------------------------------------------------------
// bzf_stack_ram: simple dual port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bzf_stack_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bzf_flat_unit.sv
// ----------------------------------------------------------------------------
// bzf_flat_unit: multi-cycle exact flatness test
// Runs all products of the flatness test through one shared signed
// multiplier and reports flat once the two exact sides are compared.
// ----------------------------------------------------------------------------
module bzf_flat_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  bzf_pkg::seg_t         seg,
  input  bzf_pkg::tol_t         tol,
  output bzf_pkg::flat_status_t status
);

  localparam int CW  = bzf_pkg::COORD_WIDTH;
  localparam int DW  = CW + 1;           // coordinate difference
  localparam int CCW = 2 * DW + 1;       // cross product
  localparam int SW  = 2 * CW + 4;       // sum of absolute cross products
  localparam int HW  = SW / 2;           // half of the sum, for the square
  localparam int QL  = CW + 1;           // half of the squared chord length
  localparam int QW  = 2 * QL;           // squared chord length
  localparam int TW  = bzf_pkg::TOL_WIDTH + 8;
  localparam int MW  = (CW + 3 > TW + 1) ? CW + 3 : TW + 1;
  localparam int PW  = 2 * MW;
  localparam int LW  = 2 * SW;

  // Step sequence of the shared multiplier.
  localparam logic [3:0] STEP_A2DY = 4'd0;
  localparam logic [3:0] STEP_B2DX = 4'd1;
  localparam logic [3:0] STEP_A3DY = 4'd2;
  localparam logic [3:0] STEP_B3DX = 4'd3;
  localparam logic [3:0] STEP_DXDX = 4'd4;
  localparam logic [3:0] STEP_DYDY = 4'd5;
  localparam logic [3:0] STEP_SHSH = 4'd6;
  localparam logic [3:0] STEP_SHSL = 4'd7;
  localparam logic [3:0] STEP_SLSL = 4'd8;
  localparam logic [3:0] STEP_TQLO = 4'd9;
  localparam logic [3:0] STEP_TQHI = 4'd10;
  localparam logic [3:0] STEP_LAST = 4'd11;
  localparam logic [3:0] STEP_DONE = 4'd12;

  logic                  busy;
  logic [3:0]            step;
  logic signed [DW-1:0]  dx, dy, a2, b2, a3, b3;
  logic signed [MW-1:0]  ma, mb;
  logic signed [PW-1:0]  prod;
  logic signed [CCW-1:0] c2, c3;
  logic [CCW-1:0]        abs2, abs3;
  logic [SW-1:0]         s;
  logic [QW-1:0]         q;
  logic [LW-1:0]         lhs, rhs;
  logic [LW-1:0]         prod_wide;
  logic [TW-1:0]         tol_scaled;

  assign tol_scaled = {tol, 8'd0};
  assign prod_wide  = LW'($unsigned(prod));

  // Sequence control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_A2DY;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_A2DY;
    end else if (busy) begin
      if (step == STEP_DONE) begin
        busy <= 1'b0;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  // Coordinate differences are captured once per test.
  always_ff @(posedge clk) begin
    if (start) begin
      dx <= DW'(seg[6]) - DW'(seg[0]);
      dy <= DW'(seg[7]) - DW'(seg[1]);
      a2 <= DW'(seg[2]) - DW'(seg[6]);
      b2 <= DW'(seg[3]) - DW'(seg[7]);
      a3 <= DW'(seg[4]) - DW'(seg[6]);
      b3 <= DW'(seg[5]) - DW'(seg[7]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      STEP_A2DY: begin ma = MW'(a2); mb = MW'(dy); end
      STEP_B2DX: begin ma = MW'(b2); mb = MW'(dx); end
      STEP_A3DY: begin ma = MW'(a3); mb = MW'(dy); end
      STEP_B3DX: begin ma = MW'(b3); mb = MW'(dx); end
      STEP_DXDX: begin ma = MW'(dx); mb = MW'(dx); end
      STEP_DYDY: begin ma = MW'(dy); mb = MW'(dy); end
      STEP_SHSH: begin
        ma = $signed(MW'(s[SW-1:HW]));
        mb = $signed(MW'(s[SW-1:HW]));
      end
      STEP_SHSL: begin
        ma = $signed(MW'(s[SW-1:HW]));
        mb = $signed(MW'(s[HW-1:0]));
      end
      STEP_SLSL: begin
        ma = $signed(MW'(s[HW-1:0]));
        mb = $signed(MW'(s[HW-1:0]));
      end
      STEP_TQLO: begin
        ma = $signed(MW'(tol_scaled));
        mb = $signed(MW'(q[QL-1:0]));
      end
      STEP_TQHI: begin
        ma = $signed(MW'(tol_scaled));
        mb = $signed(MW'(q[QW-1:QL]));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Absolute values of the cross products.
  assign abs2 = c2[CCW-1] ? CCW'(-c2) : CCW'(c2);
  assign abs3 = c3[CCW-1] ? CCW'(-c3) : CCW'(c3);

  // Multiply, then fold the product issued in the previous step.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (busy) begin
      case (step)
        STEP_B2DX: c2 <= $signed(prod[CCW-1:0]);
        STEP_A3DY: c2 <= c2 - $signed(prod[CCW-1:0]);
        STEP_B3DX: c3 <= $signed(prod[CCW-1:0]);
        STEP_DXDX: c3 <= c3 - $signed(prod[CCW-1:0]);
        STEP_DYDY: begin
          q <= prod[QW-1:0];
          s <= SW'(abs2) + SW'(abs3);
        end
        STEP_SHSH: q   <= q + prod[QW-1:0];
        STEP_SHSL: lhs <= prod_wide << SW;
        STEP_SLSL: lhs <= lhs + (prod_wide << (HW + 1));
        STEP_TQLO: lhs <= lhs + prod_wide;
        STEP_TQHI: rhs <= prod_wide;
        STEP_LAST: rhs <= rhs + (prod_wide << QL);
        default: begin
        end
      endcase
    end
  end

  assign status.done = busy && (step == STEP_DONE);
  assign status.flat = lhs < rhs;

endmodule

>>> dv/cubic_bezier_flattener_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_checker: point predictor and output checker
// Watches the configuration, curve and point channels. For every accepted
// curve it subdivides the curve itself and queues the expected points, then
// compares each accepted point with the oldest expected one.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bzf_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bzf_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  bzf_pkg::tol_t       cfg_data,
  output int                  mismatches,
  output int                  points_owed
);

  localparam int MAX_POINTS = 1 << bzf_pkg::MAX_LEVEL;

  bzf_pkg::tol_t      tolerance;
  bzf_pkg::out_item_t expected_points[$];
  longint             seg[8];

  assign points_owed = expected_points.size();

  // Exact flatness test of the segment in seg.
  function automatic bit seg_is_flat();
    logic signed [127:0] dx, dy, c2, c3, sum, lhs, rhs, tol_wide;
    dx = seg[6] - seg[0];
    dy = seg[7] - seg[1];
    c2 = 128'(seg[2] - seg[6]) * dy - 128'(seg[3] - seg[7]) * dx;
    c3 = 128'(seg[4] - seg[6]) * dy - 128'(seg[5] - seg[7]) * dx;
    if (c2 < 0) c2 = -c2;
    if (c3 < 0) c3 = -c3;
    sum = c2 + c3;
    lhs = sum * sum;
    tol_wide = {112'd0, tolerance};
    rhs = tol_wide * 256 * (dx * dx + dy * dy);
    return lhs < rhs;
  endfunction

  // Depth-first midpoint subdivision of one curve into expected points.
  function automatic void flatten_curve(bzf_pkg::in_item_t c);
    longint             stack_seg[bzf_pkg::MAX_LEVEL][8];
    int                 stack_lvl[bzf_pkg::MAX_LEVEL];
    int                 depth, lvl, n;
    bit                 held_v;
    longint             hx, hy;
    longint             x12, y12, x23, y23, x34, y34, x123, y123, x234, y234, xm, ym;
    bzf_pkg::out_item_t r;
    depth = 0; lvl = 0; n = 0; held_v = 0; hx = 0; hy = 0;
    seg[0] = c.start_x; seg[1] = c.start_y; seg[2] = c.ctrl1_x; seg[3] = c.ctrl1_y;
    seg[4] = c.ctrl2_x; seg[5] = c.ctrl2_y; seg[6] = c.end_x;   seg[7] = c.end_y;
    forever begin
      if (seg_is_flat()) begin
        if (held_v && n < MAX_POINTS - 1) begin
          r = '{point_x: bzf_pkg::coord_t'(hx), point_y: bzf_pkg::coord_t'(hy),
                point_valid: 1'b1, last_point: 1'b0};
          expected_points.push_back(r);
          n++;
        end
        hx = seg[6]; hy = seg[7]; held_v = 1;
      end else if (lvl < bzf_pkg::MAX_LEVEL && depth < bzf_pkg::MAX_LEVEL) begin
        // Split at t = 1/2; midpoints round toward minus infinity.
        x12 = (seg[0] + seg[2]) >>> 1;  y12 = (seg[1] + seg[3]) >>> 1;
        x23 = (seg[2] + seg[4]) >>> 1;  y23 = (seg[3] + seg[5]) >>> 1;
        x34 = (seg[4] + seg[6]) >>> 1;  y34 = (seg[5] + seg[7]) >>> 1;
        x123 = (x12 + x23) >>> 1;       y123 = (y12 + y23) >>> 1;
        x234 = (x23 + x34) >>> 1;       y234 = (y23 + y34) >>> 1;
        xm = (x123 + x234) >>> 1;       ym = (y123 + y234) >>> 1;
        stack_seg[depth][0] = xm;   stack_seg[depth][1] = ym;
        stack_seg[depth][2] = x234; stack_seg[depth][3] = y234;
        stack_seg[depth][4] = x34;  stack_seg[depth][5] = y34;
        stack_seg[depth][6] = seg[6]; stack_seg[depth][7] = seg[7];
        stack_lvl[depth] = lvl + 1;
        depth++;
        seg[2] = x12; seg[3] = y12; seg[4] = x123; seg[5] = y123;
        seg[6] = xm;  seg[7] = ym;
        lvl++;
        continue;
      end
      if (depth == 0) break;
      depth--;
      for (int i = 0; i < 8; i++) seg[i] = stack_seg[depth][i];
      lvl = stack_lvl[depth];
    end
    // The final result carries the held point, or marks an empty run.
    if (held_v)
      r = '{point_x: bzf_pkg::coord_t'(hx), point_y: bzf_pkg::coord_t'(hy),
            point_valid: 1'b1, last_point: 1'b1};
    else
      r = '{point_x: '0, point_y: '0, point_valid: 1'b0, last_point: 1'b1};
    expected_points.push_back(r);
  endfunction

  // Track each transaction on the three channels.
  always @(posedge clk) begin
    bzf_pkg::out_item_t e;
    if (rst) begin
      tolerance  = bzf_pkg::TOL_RESET;
      mismatches = 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (in_valid && in_ready) flatten_curve(in_data);
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected point: x=%0d y=%0d valid=%0b last=%0b",
                     out_data.point_x, out_data.point_y, out_data.point_valid,
                     out_data.last_point);
        end else begin
          e = expected_points.pop_front();
          if (e.point_x !== out_data.point_x || e.point_y !== out_data.point_y ||
              e.point_valid !== out_data.point_valid ||
              e.last_point !== out_data.last_point) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Point mismatch: expected x=%0d y=%0d valid=%0b last=%0b,",
                        " got x=%0d y=%0d valid=%0b last=%0b"},
                       e.point_x, e.point_y, e.point_valid, e.last_point,
                       out_data.point_x, out_data.point_y, out_data.point_valid,
                       out_data.last_point);
          end
        end
      end
    end
  end

endmodule

>>> dv/cubic_bezier_flattener_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_top_test: testbench of the Bezier flattener
// Sends directed and random curves through several tolerance settings and
// idle patterns; the checker predicts and compares every emitted point.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_top_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk;
  logic               rst;
  logic               in_valid, in_ready;
  bzf_pkg::in_item_t  in_data;
  logic               out_valid, out_ready;
  bzf_pkg::out_item_t out_data;
  logic               cfg_valid, cfg_ready;
  bzf_pkg::tol_t      cfg_data;
  int                 mismatches, points_owed;
  int                 send_idle_pct, recv_stall_pct;
  int                 quiet_cycles;

  cubic_bezier_flattener_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  cubic_bezier_flattener_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .points_owed(points_owed)
  );

  // Clock generation.
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one curve, with a random gap before it. Valid is left for the next
  // call or for stop_sending to change at the same falling edge.
  task automatic send_curve(bzf_pkg::in_item_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop the curve channel's valid after the last transaction.
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Change the tolerance once every expected point has come out.
  task automatic set_tolerance(bzf_pkg::tol_t tol);
    stop_sending();
    while (points_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bzf_pkg::coord_t near(bzf_pkg::coord_t base, int spread);
    return bzf_pkg::coord_t'(base + $signed($urandom_range(2 * spread)) - spread);
  endfunction

  // Random curve: mostly local curves of random size, sometimes full range.
  function automatic bzf_pkg::in_item_t random_curve();
    bzf_pkg::in_item_t c;
    bzf_pkg::coord_t   bx, by;
    int                spread;
    if ($urandom_range(9) == 0) begin
      c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      spread = 1 << $urandom_range(18, 2);
      bx = bzf_pkg::coord_t'($urandom());
      by = bzf_pkg::coord_t'($urandom());
      if (bx > 24'sd4000000 || bx < -24'sd4000000) bx = bx >>> 2;
      if (by > 24'sd4000000 || by < -24'sd4000000) by = by >>> 2;
      c = '{start_x: near(bx, spread), start_y: near(by, spread),
            ctrl1_x: near(bx, spread), ctrl1_y: near(by, spread),
            ctrl2_x: near(bx, spread), ctrl2_y: near(by, spread),
            end_x: near(bx, spread),   end_y: near(by, spread)};
    end
    return c;
  endfunction

  localparam bzf_pkg::coord_t CMAX = 24'sh7FFFFF;
  localparam bzf_pkg::coord_t CMIN = 24'sh800000;

  initial begin
    bzf_pkg::tol_t tols[6];
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed curves at the reset tolerance.
    send_curve('{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX});
    send_curve('{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX});
    send_curve('{0, 0, 256, 0, 512, 0, 768, 0});                 // straight line
    send_curve('{0, 0, 2560, 5120, 7680, 5120, 10240, 0});       // arch
    send_curve('{100, 100, 5000, -3000, -4000, 7000, 100, 100}); // closed loop
    send_curve('{0, 0, 0, 0, 0, 0, 0, 0});                       // point
    send_curve('{-1, -1, -1, 0, 0, -1, 0, 0});
    send_curve('{CMIN, 0, CMAX, 0, CMIN, 0, CMAX, 0});
    send_curve('{0, CMAX, 0, CMIN, 0, CMAX, 0, CMIN});
    send_curve('{-5000, 300, 9000, 9000, -9000, -9000, 5000, -300}); // S curve
    for (int i = 0; i < 6; i++) send_curve(random_curve());
    set_tolerance(16'd0);                                         // nothing is flat
    send_curve('{0, 0, 2560, 5120, 7680, 5120, 10240, 0});
    send_curve('{0, 0, 256, 0, 512, 0, 768, 0});
    set_tolerance(16'hFFFF);
    send_curve('{0, 0, 2560, 5120, 7680, 5120, 10240, 0});
    send_curve('{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX});

    // Random curves over idle patterns and tolerance settings.
    tols = '{16'd64, 16'd1, 16'd0, 16'hFFFF, 16'd256, 16'd8};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int k = 0; k < 2; k++) begin
        set_tolerance((k == 0) ? tols[(phase + k) % 6]
                               : bzf_pkg::tol_t'($urandom_range(300)));
        for (int i = 0; i < 16; i++) send_curve(random_curve());
      end
    end
    set_tolerance(tols[5]);
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 10; i++) send_curve(random_curve());
    stop_sending();

    // Drain and settle.
    while (points_owed != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && points_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
